FILE: src/nearest_point_pick_defines.svh
// Assertion macros shared by the point picker RTL.
`ifndef NEAREST_POINT_PICK_DEFINES_SVH
`define NEAREST_POINT_PICK_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define NPP_ASSERT_HOLDS(name, cond, rhs, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define NPP_ASSERT_NEXT(name, cond, rhs, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (rhs)) \
      else $error(msg);

`endif

FILE: src/npp_pkg.sv
// Types, constants and state encodings of the nearest point picker.
package npp_pkg;

   localparam int CLIP_W        = 42;   // clip coordinate, Q26.16 after the >>> 8
   localparam int ACC_W         = 50;   // sum of products
   localparam int MUL_A_W       = 22;
   localparam int MUL_B_W       = 32;
   localparam int DIST_W        = 22;   // NDC minus cursor
   localparam int NDC_W         = 21;
   localparam int QMAG_W        = 20;   // quotient magnitude bits
   localparam int NDC_FRAC      = 14;
   localparam int NDC_PRE_SHIFT = QMAG_W - NDC_FRAC;
   localparam int DEPTH_Q_W     = 15;
   localparam int ROW_W_SHIFT   = 16;   // fourth column times 1.0 in Q16.16
   localparam int CLIP_SHIFT    = 8;
   localparam int STEP_W        = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int RADIUS_W      = 15;

   localparam logic [STEP_W-1:0] DEPTH_STEPS = STEP_W'(DEPTH_Q_W);
   localparam logic [STEP_W-1:0] NDC_STEPS   = STEP_W'(QMAG_W);

   localparam logic [15:0] DEPTH_ONE = 16'h8000;
   localparam logic signed [NDC_W-1:0] NDC_SAT_MAX = {1'b0, {(NDC_W-1){1'b1}}};
   localparam logic signed [NDC_W-1:0] NDC_SAT_MIN = {1'b1, {(NDC_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ROW3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_NDC  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PICK_RADIUS = 3'd5;

   localparam logic [CSR_DATA_W-1:0] MATRIX_ROW0_RST = 64'h0000_0000_0000_0100;
   localparam logic [CSR_DATA_W-1:0] MATRIX_ROW1_RST = 64'h0000_0000_0100_0000;
   localparam logic [CSR_DATA_W-1:0] MATRIX_ROW2_RST = 64'h0000_0100_0000_0000;
   localparam logic [CSR_DATA_W-1:0] MATRIX_ROW3_RST = 64'h0100_0000_0000_0000;
   localparam logic [RADIUS_W-1:0]   PICK_RADIUS_RST = 15'd492;

   typedef struct packed {
      logic [31:0]        entity_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] picked_entity;
      logic [15:0] picked_depth;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic                     mode_ndc;
      logic signed [CLIP_W-1:0] num;
      logic signed [CLIP_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic              neg;
      logic [QMAG_W-1:0] mag;
   } div_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAT_MUL,
      ST_MAT_ACC,
      ST_MAT_ROW,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_FINISH
   } pick_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_RUN
   } div_state_type;

endpackage

FILE: src/nearest_point_pick.sv
// Nearest point picker: takes one point per request and reports the nearest
// point under the cursor when a request marked last has been worked through.
// The block stalls its input while a request is worked through: the matrix
// transform runs on the one shared 22x32 multiplier (3 products per row, each
// issued then accumulated, then a step to close the row), then come three
// divisions on the shared bit-serial divider (depth, NDC x and NDC y), the
// squared distance on the same multiplier, and a step each to accept and to
// finish. A point with w of zero skips the divisions and the distance, and
// one with depth out of range leaves after the depth division. A result waits
// in its own register; the block accepts further requests meanwhile, and only
// a following last request waits for it to drain.
`include "nearest_point_pick_defines.svh"

module nearest_point_pick (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  npp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output npp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [npp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [npp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   npp_pkg::pick_state_type state_ff, state_in;
   npp_pkg::req_type        item_ff;

   logic [npp_pkg::CSR_DATA_W-1:0] matrix_ff [4];
   logic [31:0]                    cursor_ff;
   logic [npp_pkg::RADIUS_W-1:0]   radius_ff;

   logic [1:0] row_ff, row_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] div_idx_ff, div_idx_in;

   logic signed [npp_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [npp_pkg::ACC_W-1:0]  prod_ff;
   logic signed [npp_pkg::CLIP_W-1:0] clip_ff [4];
   logic signed [npp_pkg::CLIP_W-1:0] clip_in;
   logic                              clip_we;
   logic [npp_pkg::DEPTH_Q_W-1:0]     depth_ff, depth_in;
   logic signed [npp_pkg::DIST_W-1:0] dx_ff, dx_in;
   logic signed [npp_pkg::DIST_W-1:0] dy_ff, dy_in;

   logic [31:0] best_entity_ff, best_entity_in;
   logic [15:0] best_depth_ff, best_depth_in;
   logic        have_pick_ff, have_pick_in;
   logic        rsp_valid_ff, rsp_valid_in;
   npp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [npp_pkg::MUL_A_W-1:0]                 mul_a;
   logic signed [npp_pkg::MUL_B_W-1:0]                 mul_b;
   logic signed [npp_pkg::MUL_A_W+npp_pkg::MUL_B_W-1:0] prod_full;

   logic [npp_pkg::CSR_DATA_W-1:0]    row_word;
   logic signed [15:0]                lane_sel;
   logic signed [15:0]                lane_w;
   logic signed [31:0]                pos_sel;
   logic signed [npp_pkg::ACC_W-1:0]  row_sum;
   logic signed [npp_pkg::NDC_W-1:0]  ndc;
   logic signed [npp_pkg::NDC_W-1:0]  mag_s;
   logic signed [15:0]                ndc_cur;
   logic signed [npp_pkg::DIST_W-1:0] ndc_diff;
   logic                              depth_ok;
   logic                              dist_pass;
   logic                              w_zero;
   logic                              out_free;
   logic                              accept;

   npp_pkg::div_cmd_type div_cmd;
   npp_pkg::div_res_type div_res;

   npp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_stall = (state_ff != npp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0] <= npp_pkg::MATRIX_ROW0_RST;
         matrix_ff[1] <= npp_pkg::MATRIX_ROW1_RST;
         matrix_ff[2] <= npp_pkg::MATRIX_ROW2_RST;
         matrix_ff[3] <= npp_pkg::MATRIX_ROW3_RST;
         cursor_ff    <= '0;
         radius_ff    <= npp_pkg::PICK_RADIUS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            npp_pkg::CSR_MATRIX_ROW0: matrix_ff[0] <= csr_wdata;
            npp_pkg::CSR_MATRIX_ROW1: matrix_ff[1] <= csr_wdata;
            npp_pkg::CSR_MATRIX_ROW2: matrix_ff[2] <= csr_wdata;
            npp_pkg::CSR_MATRIX_ROW3: matrix_ff[3] <= csr_wdata;
            npp_pkg::CSR_CURSOR_NDC:  cursor_ff    <= csr_wdata[31:0];
            npp_pkg::CSR_PICK_RADIUS: radius_ff    <= csr_wdata[npp_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- shared multiplier operands
   assign row_word = matrix_ff[row_ff];
   assign lane_w   = signed'(row_word[63:48]);

   always_comb begin
      case (idx_ff)
         2'd0:    lane_sel = signed'(row_word[15:0]);
         2'd1:    lane_sel = signed'(row_word[31:16]);
         default: lane_sel = signed'(row_word[47:32]);
      endcase
      case (idx_ff)
         2'd0:    pos_sel = item_ff.pos_x;
         2'd1:    pos_sel = item_ff.pos_y;
         default: pos_sel = item_ff.pos_z;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         npp_pkg::ST_MAT_MUL: begin
            mul_a = npp_pkg::MUL_A_W'(lane_sel);
            mul_b = pos_sel;
         end
         npp_pkg::ST_SQ_MUL: begin
            case (idx_ff)
               2'd0: begin
                  mul_a = dx_ff;
                  mul_b = npp_pkg::MUL_B_W'(dx_ff);
               end
               2'd1: begin
                  mul_a = dy_ff;
                  mul_b = npp_pkg::MUL_B_W'(dy_ff);
               end
               default: begin
                  mul_a = npp_pkg::MUL_A_W'({1'b0, radius_ff});
                  mul_b = npp_pkg::MUL_B_W'({1'b0, radius_ff});
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   // floor shift of the row sum, fourth column adds w = 1.0
   assign row_sum = acc_ff + (npp_pkg::ACC_W'(lane_w) <<< npp_pkg::ROW_W_SHIFT);
   assign clip_in = npp_pkg::CLIP_W'(row_sum >>> npp_pkg::CLIP_SHIFT);
   assign w_zero  = (clip_ff[3] == '0);

   // ---------------- divider command and result shaping
   always_comb begin
      div_cmd.start    = (state_ff == npp_pkg::ST_DIV_START) && !w_zero;
      div_cmd.mode_ndc = (div_idx_ff != 2'd0);
      div_cmd.den      = clip_ff[3];
      case (div_idx_ff)
         2'd0:    div_cmd.num = clip_ff[2];
         2'd1:    div_cmd.num = clip_ff[0];
         default: div_cmd.num = clip_ff[1];
      endcase
   end

   assign depth_ok = !div_res.ovf && !div_res.neg && (div_res.mag != '0);
   assign mag_s    = signed'({1'b0, div_res.mag});

   always_comb begin
      if (div_res.ovf) begin
         ndc = div_res.neg ? npp_pkg::NDC_SAT_MIN : npp_pkg::NDC_SAT_MAX;
      end else begin
         ndc = div_res.neg ? -mag_s : mag_s;
      end
   end

   assign ndc_cur   = (div_idx_ff == 2'd1) ? signed'(cursor_ff[15:0])
                                           : signed'(cursor_ff[31:16]);
   assign ndc_diff  = npp_pkg::DIST_W'(ndc) - npp_pkg::DIST_W'(ndc_cur);
   assign dist_pass = acc_ff < prod_ff;

   // ---------------- sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npp_pkg::ST_IDLE: begin
            if (accept) state_in = npp_pkg::ST_MAT_MUL;
         end
         npp_pkg::ST_MAT_MUL: state_in = npp_pkg::ST_MAT_ACC;
         npp_pkg::ST_MAT_ACC: begin
            state_in = (idx_ff == 2'd2) ? npp_pkg::ST_MAT_ROW : npp_pkg::ST_MAT_MUL;
         end
         npp_pkg::ST_MAT_ROW: begin
            state_in = (row_ff == 2'd3) ? npp_pkg::ST_DIV_START : npp_pkg::ST_MAT_MUL;
         end
         npp_pkg::ST_DIV_START: begin
            state_in = w_zero ? npp_pkg::ST_FINISH : npp_pkg::ST_DIV_WAIT;
         end
         npp_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               if (div_idx_ff == 2'd0 && !depth_ok) begin
                  state_in = npp_pkg::ST_FINISH;
               end else if (div_idx_ff == 2'd2) begin
                  state_in = npp_pkg::ST_SQ_MUL;
               end else begin
                  state_in = npp_pkg::ST_DIV_START;
               end
            end
         end
         npp_pkg::ST_SQ_MUL: state_in = npp_pkg::ST_SQ_ACC;
         npp_pkg::ST_SQ_ACC: begin
            state_in = (idx_ff == 2'd2) ? npp_pkg::ST_FINISH : npp_pkg::ST_SQ_MUL;
         end
         npp_pkg::ST_FINISH: begin
            if (!item_ff.last || out_free) state_in = npp_pkg::ST_IDLE;
         end
         default: state_in = npp_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: datapath and result controls
   always_comb begin
      row_in         = row_ff;
      idx_in         = idx_ff;
      div_idx_in     = div_idx_ff;
      acc_in         = acc_ff;
      clip_we        = 1'b0;
      depth_in       = depth_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      best_entity_in = best_entity_ff;
      best_depth_in  = best_depth_ff;
      have_pick_in   = have_pick_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         npp_pkg::ST_IDLE: begin
            if (accept) begin
               row_in = 2'd0;
               idx_in = 2'd0;
               acc_in = '0;
            end
         end
         npp_pkg::ST_MAT_ACC: begin
            acc_in = acc_ff + prod_ff;
            idx_in = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         npp_pkg::ST_MAT_ROW: begin
            clip_we    = 1'b1;
            acc_in     = '0;
            row_in     = row_ff + 2'd1;
            div_idx_in = 2'd0;
         end
         npp_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               case (div_idx_ff)
                  2'd0: begin
                     depth_in   = div_res.mag[npp_pkg::DEPTH_Q_W-1:0];
                     div_idx_in = 2'd1;
                  end
                  2'd1: begin
                     dx_in      = ndc_diff;
                     div_idx_in = 2'd2;
                  end
                  default: begin
                     dy_in  = ndc_diff;
                     idx_in = 2'd0;
                     acc_in = '0;
                  end
               endcase
            end
         end
         npp_pkg::ST_SQ_ACC: begin
            if (idx_ff != 2'd2) begin
               acc_in = acc_ff + prod_ff;
               idx_in = idx_ff + 2'd1;
            end else begin
               idx_in = 2'd0;
               // ties keep the earlier point
               if (dist_pass && ({1'b0, depth_ff} < best_depth_ff)) begin
                  best_entity_in = item_ff.entity_id;
                  best_depth_in  = {1'b0, depth_ff};
                  have_pick_in   = 1'b1;
               end
            end
         end
         npp_pkg::ST_FINISH: begin
            if (item_ff.last && out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.found         = have_pick_ff;
               rsp_data_in.picked_entity = have_pick_ff ? best_entity_ff : 32'd0;
               rsp_data_in.picked_depth  = have_pick_ff ? best_depth_ff : npp_pkg::DEPTH_ONE;
               best_entity_in            = '0;
               best_depth_in             = npp_pkg::DEPTH_ONE;
               have_pick_in              = 1'b0;
            end
         end
         default: begin
            clip_we = 1'b0;
         end
      endcase
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= npp_pkg::ST_IDLE;
         row_ff         <= '0;
         idx_ff         <= '0;
         div_idx_ff     <= '0;
         best_entity_ff <= '0;
         best_depth_ff  <= npp_pkg::DEPTH_ONE;
         have_pick_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         idx_ff         <= idx_in;
         div_idx_ff     <= div_idx_in;
         best_entity_ff <= best_entity_in;
         best_depth_ff  <= best_depth_in;
         have_pick_ff   <= have_pick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      if (clip_we) clip_ff[row_ff] <= clip_in;
      prod_ff     <= prod_full[npp_pkg::ACC_W-1:0];
      acc_ff      <= acc_in;
      depth_ff    <= depth_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- checks
   `NPP_ASSERT_HOLDS(a_pick_depth_range, have_pick_ff, (best_depth_ff != 16'd0) && (best_depth_ff < npp_pkg::DEPTH_ONE), "held pick has depth outside the open unit range")
   `NPP_ASSERT_HOLDS(a_empty_pick_clear, !have_pick_ff, (best_depth_ff == npp_pkg::DEPTH_ONE) && (best_entity_ff == 32'd0), "empty pick state not at its cleared values")
   `NPP_ASSERT_NEXT(a_result_loaded, (state_ff == npp_pkg::ST_FINISH) && item_ff.last && out_free, rsp_valid_ff && !have_pick_ff && (state_ff == npp_pkg::ST_IDLE), "last request finished without a result and a cleared pick")
   `NPP_ASSERT_HOLDS(a_div_done_waited, div_res.done, state_ff == npp_pkg::ST_DIV_WAIT, "divider finished while the sequencer was not waiting on it")

endmodule

FILE: src/npp_div.sv
// Restoring divider, one quotient bit per cycle, for depth and NDC quotients.
module npp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  npp_pkg::div_cmd_type cmd,
   output npp_pkg::div_res_type res
);

   npp_pkg::div_state_type state_ff, state_in;
   logic [npp_pkg::CLIP_W:0]   rem_ff, rem_in;
   logic [npp_pkg::CLIP_W-1:0] den_ff, den_in;
   logic [npp_pkg::QMAG_W-1:0] low_ff, low_in;
   logic [npp_pkg::QMAG_W-1:0] quo_ff, quo_in;
   logic [npp_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic ovf_ff, ovf_in;
   logic done_ff, done_in;

   logic [npp_pkg::CLIP_W-1:0] num_abs;
   logic [npp_pkg::CLIP_W-1:0] den_abs;
   logic [npp_pkg::CLIP_W:0]   den_ext;
   logic [npp_pkg::CLIP_W:0]   trial;
   logic                       fits;
   logic                       too_big;

   assign num_abs = cmd.num[npp_pkg::CLIP_W-1] ? unsigned'(-cmd.num) : unsigned'(cmd.num);
   assign den_abs = cmd.den[npp_pkg::CLIP_W-1] ? unsigned'(-cmd.den) : unsigned'(cmd.den);
   assign den_ext = {1'b0, den_ff};
   // remainder stays below the divisor, so its top bit is free to shift out
   assign trial   = {rem_ff[npp_pkg::CLIP_W-1:0], low_ff[npp_pkg::QMAG_W-1]};
   assign fits    = trial >= den_ext;
   assign too_big = rem_ff >= den_ext;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npp_pkg::DIV_IDLE: begin
            if (cmd.start) state_in = npp_pkg::DIV_CHECK;
         end
         npp_pkg::DIV_CHECK: begin
            state_in = too_big ? npp_pkg::DIV_IDLE : npp_pkg::DIV_RUN;
         end
         npp_pkg::DIV_RUN: begin
            if (cnt_ff == npp_pkg::STEP_W'(1)) state_in = npp_pkg::DIV_IDLE;
         end
         default: state_in = npp_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      case (state_ff)
         npp_pkg::DIV_IDLE: begin
            if (cmd.start) begin
               // the high part of the scaled dividend must be below the divisor
               if (cmd.mode_ndc) begin
                  rem_in = {1'b0, num_abs} >> npp_pkg::NDC_PRE_SHIFT;
                  low_in = {num_abs[npp_pkg::NDC_PRE_SHIFT-1:0], {npp_pkg::NDC_FRAC{1'b0}}};
                  cnt_in = npp_pkg::NDC_STEPS;
               end else begin
                  rem_in = {1'b0, num_abs};
                  low_in = '0;
                  cnt_in = npp_pkg::DEPTH_STEPS;
               end
               den_in = den_abs;
               neg_in = cmd.num[npp_pkg::CLIP_W-1] ^ cmd.den[npp_pkg::CLIP_W-1];
               quo_in = '0;
               ovf_in = 1'b0;
            end
         end
         npp_pkg::DIV_CHECK: begin
            if (too_big) begin
               ovf_in  = 1'b1;
               done_in = 1'b1;
            end
         end
         npp_pkg::DIV_RUN: begin
            rem_in = fits ? (trial - den_ext) : trial;
            quo_in = {quo_ff[npp_pkg::QMAG_W-2:0], fits};
            low_in = low_ff << 1;
            cnt_in = cnt_ff - npp_pkg::STEP_W'(1);
            if (cnt_ff == npp_pkg::STEP_W'(1)) done_in = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npp_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      res.done = done_ff;
      res.ovf  = ovf_ff;
      res.neg  = neg_ff;
      res.mag  = quo_ff;
   end

endmodule

FILE: tb/nearest_point_pick_checker.sv
// Checker for the point picker: tracks the nearest point per frame and checks each pick result.
module nearest_point_pick_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  npp_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  npp_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [npp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [npp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fails,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import npp_pkg::*;

   localparam longint DEPTH_FULL = 32768;
   localparam longint NDC_TOP    = 1048575;
   localparam longint NDC_BOTTOM = -1048576;

   logic [63:0] mat_row [4];
   logic [31:0] cursor;
   logic [14:0] radius;
   logic [31:0] near_entity;
   logic [15:0] near_depth;
   bit          near_valid;
   rsp_type     picks_due [$];
   int          fail_cnt = 0;

   function automatic longint lane_of(logic [63:0] row, int col);
      return longint'($signed(row[16*col +: 16]));
   endfunction

   // Q8.8 x Q16.16 products summed exactly, floor back to Q16.16
   function automatic longint clip_of(logic [63:0] row, longint x, longint y, longint z);
      longint acc;
      acc = lane_of(row, 0) * x + lane_of(row, 1) * y + lane_of(row, 2) * z
          + lane_of(row, 3) * 65536;
      return acc >>> 8;
   endfunction

   function automatic longint clamp_ndc(longint v);
      if (v > NDC_TOP)
         return NDC_TOP;
      if (v < NDC_BOTTOM)
         return NDC_BOTTOM;
      return v;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      longint  px, py, pz, cx, cy, cz, cw, q, nx, ny, dx, dy, r;
      if (reset) begin
         mat_row[0] = MATRIX_ROW0_RST;
         mat_row[1] = MATRIX_ROW1_RST;
         mat_row[2] = MATRIX_ROW2_RST;
         mat_row[3] = MATRIX_ROW3_RST;
         cursor = '0;
         radius = PICK_RADIUS_RST;
         near_entity = '0;
         near_depth = DEPTH_ONE;
         near_valid = 1'b0;
         picks_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATRIX_ROW0: mat_row[0] = csr_wdata;
               CSR_MATRIX_ROW1: mat_row[1] = csr_wdata;
               CSR_MATRIX_ROW2: mat_row[2] = csr_wdata;
               CSR_MATRIX_ROW3: mat_row[3] = csr_wdata;
               CSR_CURSOR_NDC:  cursor = csr_wdata[31:0];
               CSR_PICK_RADIUS: radius = csr_wdata[14:0];
               default: ;
            endcase
         end

         // results are checked before this edge's request is predicted
         if (rsp_valid && !rsp_stall) begin
            if (picks_due.size() == 0) begin
               $error("pick result with none expected: found %0b entity %0h depth %0h",
                      rsp_data.found, rsp_data.picked_entity, rsp_data.picked_depth);
               fail_cnt++;
            end else begin
               want = picks_due.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0b actual %0b", want.found, rsp_data.found);
                  fail_cnt++;
               end
               if (rsp_data.picked_entity !== want.picked_entity) begin
                  $error("picked_entity: expected %0h actual %0h",
                         want.picked_entity, rsp_data.picked_entity);
                  fail_cnt++;
               end
               if (rsp_data.picked_depth !== want.picked_depth) begin
                  $error("picked_depth: expected %0h actual %0h",
                         want.picked_depth, rsp_data.picked_depth);
                  fail_cnt++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            px = longint'($signed(req_data.pos_x));
            py = longint'($signed(req_data.pos_y));
            pz = longint'($signed(req_data.pos_z));
            cx = clip_of(mat_row[0], px, py, pz);
            cy = clip_of(mat_row[1], px, py, pz);
            cz = clip_of(mat_row[2], px, py, pz);
            cw = clip_of(mat_row[3], px, py, pz);
            // zero w drops the point without touching the pick
            if (cw != 0) begin
               q  = (cz * DEPTH_FULL) / cw;
               nx = clamp_ndc((cx * 16384) / cw);
               ny = clamp_ndc((cy * 16384) / cw);
               dx = nx - longint'($signed(cursor[15:0]));
               dy = ny - longint'($signed(cursor[31:16]));
               r  = longint'(radius);
               // strict compare keeps the earlier point on equal depth
               if (q > 0 && q < DEPTH_FULL && dx * dx + dy * dy < r * r
                   && q < longint'(near_depth)) begin
                  near_entity = req_data.entity_id;
                  near_depth  = q[15:0];
                  near_valid  = 1'b1;
               end
            end
            if (req_data.last) begin
               want.found         = near_valid;
               want.picked_entity = near_valid ? near_entity : '0;
               want.picked_depth  = near_valid ? near_depth : DEPTH_ONE;
               picks_due.push_back(want);
               near_entity = '0;
               near_depth  = DEPTH_ONE;
               near_valid  = 1'b0;
            end
         end
      end
      fails   <= fail_cnt;
      pending <= picks_due.size();
   end

endmodule

FILE: tb/tb_nearest_point_pick.sv
// Testbench top for the point picker: clock, reset, request and register stimulus, verdict.
module tb_nearest_point_pick;
   timeunit 1ns;
   timeprecision 1ps;
   import npp_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int BUSY_CYCLES   = 120;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 50;

   // indexes past the register list, writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MATRIX_ROW0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fails;
   int                    pending;
   int                    quiet = 0;
   bit                    calm = 1'b0;

   // view the aimed points are built for: diagonal scale, constant w
   bit     aim_ok = 1'b1;
   longint aim_scale = 256;
   longint aim_w = 256;
   int     cur_x = 0;
   int     cur_y = 0;
   int     radius = 492;

   nearest_point_pick u_dut (.*);

   nearest_point_pick_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 26);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [63:0] lanes(logic [15:0] c0, c1, c2, c3);
      return {c3, c2, c1, c0};
   endfunction

   // world point landing on the given NDC x, y and Q1.15 depth under the aimed view
   function automatic req_type place(logic [31:0] ent, longint nx, longint ny, longint q,
                                     bit fin);
      req_type p;
      p.entity_id = ent;
      p.pos_x     = 32'(nx * 4 * aim_w / aim_scale);
      p.pos_y     = 32'(ny * 4 * aim_w / aim_scale);
      p.pos_z     = 32'(q * 2 * aim_w / aim_scale);
      p.last      = fin;
      return p;
   endfunction

   function automatic req_type aimed_point(bit fin);
      longint reach, q, nx, ny;
      reach = radius + radius / 4 + 2;
      if ($urandom_range(9) == 0)
         q = ($urandom_range(1) ? 32768 : -400) + longint'($urandom_range(400));
      else
         q = $urandom_range(1, 32767);
      nx = cur_x + longint'($urandom_range(2 * reach)) - reach;
      ny = cur_y + longint'($urandom_range(2 * reach)) - reach;
      return place($urandom, nx, ny, q, fin);
   endfunction

   function automatic req_type noise_point(bit fin);
      req_type p;
      int      sh;
      sh = $urandom_range(1) ? 0 : $urandom_range(31, 8);
      p.entity_id = $urandom;
      p.pos_x     = $signed($urandom) >>> sh;
      p.pos_y     = $signed($urandom) >>> sh;
      p.pos_z     = $signed($urandom) >>> sh;
      p.last      = fin;
      return p;
   endfunction

   task automatic send_point(input req_type p);
      if (!calm)
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame(int len);
      for (int i = 0; i < len; i++)
         if (aim_ok && $urandom_range(99) < 80)
            send_point(aimed_point(i == len - 1));
         else
            send_point(noise_point(i == len - 1));
   endtask

   // valid stays high after a write; callers drop it once the batch is done
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain_picks();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic wait_idle();
      drain_picks();
      repeat (BUSY_CYCLES) @(posedge clock);
   endtask

   task automatic set_view(longint s, longint wl, int cx, int cy, int rad);
      aim_ok    = 1'b1;
      aim_scale = s;
      aim_w     = wl;
      cur_x     = cx;
      cur_y     = cy;
      radius    = rad;
      write_reg(CSR_MATRIX_ROW0, lanes(16'(s), '0, '0, '0));
      write_reg(CSR_MATRIX_ROW1, lanes('0, 16'(s), '0, '0));
      write_reg(CSR_MATRIX_ROW2, lanes('0, '0, 16'(s), '0));
      write_reg(CSR_MATRIX_ROW3, lanes('0, '0, '0, 16'(wl)));
      // junk above the register width must be masked off
      write_reg(CSR_CURSOR_NDC, {$urandom, 16'(cy), 16'(cx)});
      write_reg(CSR_PICK_RADIUS, {$urandom, 17'($urandom), 15'(rad)});
      write_reg(CSR_UNUSED_LO, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic scramble_view(logic [15:0] fill, bit rnd);
      aim_ok = 1'b0;
      write_reg(CSR_MATRIX_ROW0, rnd ? {$urandom, $urandom} : {4{fill}});
      write_reg(CSR_MATRIX_ROW1, rnd ? {$urandom, $urandom} : {4{fill}});
      write_reg(CSR_MATRIX_ROW2, rnd ? {$urandom, $urandom} : {4{fill}});
      write_reg(CSR_MATRIX_ROW3, rnd ? {$urandom, $urandom} : {4{fill}});
      write_reg(CSR_CURSOR_NDC, {$urandom, $urandom});
      write_reg(CSR_PICK_RADIUS, 64'($urandom_range(16384)));
      write_reg(CSR_UNUSED_HI, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int items_left;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset view: identity matrix, cursor at the origin, radius 492
      send_point(place(32'hFFFF_FFFF, 0, 0, 16000, 1'b0));
      send_point(place(32'd5, 0, 0, 16000, 1'b0));          // same depth, first stays
      send_point(place(32'd6, 10, -10, 8000, 1'b0));
      send_point(place(32'd7, 0, 0, 0, 1'b0));              // depth zero
      send_point(place(32'd8, -20, 30, -100, 1'b0));
      send_point(place(32'd9, 492, 0, 100, 1'b0));          // exactly on the rim
      send_point(req_type'{32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0});
      send_point(place(32'd10, -491, 0, 4000, 1'b1));
      send_point(place(32'd0, 0, 0, 32767, 1'b1));          // entity zero is a real pick
      send_point(place(32'd11, 2000, 0, 100, 1'b1));        // empty frame
      send_point(place(32'd12, 0, 0, 32768, 1'b0));         // depth exactly one
      send_point(req_type'{32'hA5A5_5A5A, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1});

      // perspective view with w = z, so z of zero gives a zero w
      wait_idle();
      aim_ok = 1'b0;
      write_reg(CSR_MATRIX_ROW0, lanes(16'd256, '0, '0, '0));
      write_reg(CSR_MATRIX_ROW1, lanes('0, 16'd256, '0, '0));
      write_reg(CSR_MATRIX_ROW2, lanes('0, '0, '0, 16'd256));
      write_reg(CSR_MATRIX_ROW3, lanes('0, '0, 16'd256, '0));
      write_reg(CSR_CURSOR_NDC, '0);
      write_reg(CSR_PICK_RADIUS, '1);
      csr_valid <= 1'b0;
      send_point(req_type'{32'd21, 100, -100, 0, 1'b0});
      send_point(req_type'{32'd22, 800, 800, 3 * 65536, 1'b0});
      send_point(req_type'{32'd23, 0, 0, 65536, 1'b0});
      send_point(req_type'{32'd24, 0, 0, -131072, 1'b0});
      send_point(req_type'{32'd25, 0, 0, 0, 1'b1});         // zero w on the closing point

      wait_idle();
      write_reg(CSR_CURSOR_NDC, {32'h0, 16'h8000, 16'h7FFF});
      write_reg(CSR_PICK_RADIUS, 64'd16384);
      write_reg(CSR_UNUSED_LO, {$urandom, $urandom});
      write_reg(CSR_UNUSED_HI, {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_point(req_type'{32'd26, 131064, -131072, 131072, 1'b1});

      for (int ph = 0; ph < 10; ph++) begin
         wait_idle();
         calm = (ph == 5);
         case (ph)
            3: scramble_view(16'h7FFF, 1'b0);
            7: scramble_view(16'h8000, 1'b0);
            9: scramble_view('0, 1'b1);
            default: set_view($urandom_range(32, 1024), $urandom_range(16, 1023),
                              int'($urandom_range(65535)) - 32768,
                              int'($urandom_range(65535)) - 32768,
                              (ph == 0) ? 16384 : (ph == 4) ? 0 : $urandom_range(16, 2000));
         endcase
         items_left = PHASE_ITEMS;
         while (items_left > 0) begin
            len = $urandom_range(1, 8);
            if (len > items_left)
               len = items_left;
            send_frame(len);
            items_left -= len;
            if ($urandom_range(9) == 0)
               drain_picks();
         end
      end
      calm = 1'b0;

      drain_picks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/npp_pkg.sv
src/npp_div.sv
src/nearest_point_pick.sv
tb/nearest_point_pick_checker.sv
tb/tb_nearest_point_pick.sv
